@@ src/bqd_pkg.sv @@
package bqd_pkg;

   localparam int COEF_WIDTH = 24;
   localparam int NUM_REGS = 5;
   localparam int REG_INDEX_WIDTH = 3;

   localparam logic [REG_INDEX_WIDTH-1:0] REG_B0 = 3'd0;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_B1 = 3'd1;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_B2 = 3'd2;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_A1 = 3'd3;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_A2 = 3'd4;

   localparam logic signed [COEF_WIDTH-1:0] B0_RESET = 24'sd1048576;

   typedef logic [2:0] mul_sel_type;
   localparam mul_sel_type MUL_A1_D1 = 3'd0;
   localparam mul_sel_type MUL_A2_D2 = 3'd1;
   localparam mul_sel_type MUL_B0_W  = 3'd2;
   localparam mul_sel_type MUL_B1_D1 = 3'd3;
   localparam mul_sel_type MUL_B2_D2 = 3'd4;

   typedef logic [2:0] acc_op_type;
   localparam acc_op_type ACC_HOLD   = 3'd0;
   localparam acc_op_type ACC_LOAD_X = 3'd1;
   localparam acc_op_type ACC_CLEAR  = 3'd2;
   localparam acc_op_type ACC_ADD    = 3'd3;
   localparam acc_op_type ACC_SUB    = 3'd4;

   typedef struct packed {
      mul_sel_type mul_sel;
      logic        prod_en;
      acc_op_type  acc_op;
      logic        w_load;
      logic        out_load;
   } cmd_type;

endpackage

@@ src/bqd_req_if.sv @@
interface bqd_req_if #(
   parameter int SAMPLE_WIDTH = 24
) ();
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink (input valid, input sample_in, output ready);
endinterface

@@ src/bqd_rsp_if.sv @@
interface bqd_rsp_if #(
   parameter int SAMPLE_WIDTH = 24
) ();
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink (input valid, input sample_out, output ready);
endinterface

@@ src/bqd_datapath.sv @@
module bqd_datapath #(
   parameter int SAMPLE_WIDTH = 24,
   parameter int COEF_FRAC_BITS = 20,
   parameter int STATE_WIDTH = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_enable,
   input  logic [bqd_pkg::REG_INDEX_WIDTH-1:0]    csr_index,
   input  logic [bqd_pkg::COEF_WIDTH-1:0]         csr_write_data,
   input  logic signed [SAMPLE_WIDTH-1:0]         sample_in,
   input  bqd_pkg::cmd_type                       cmd,
   output logic signed [SAMPLE_WIDTH-1:0]         sample_out
);
   import bqd_pkg::*;

   localparam int PROD_W = COEF_WIDTH + STATE_WIDTH;
   localparam int X_W = SAMPLE_WIDTH + COEF_FRAC_BITS;
   localparam int ACC_W = ((PROD_W > X_W) ? PROD_W : X_W) + 3;

   localparam logic signed [ACC_W-1:0] HALF =
      {{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
   localparam logic signed [ACC_W-1:0] W_MAX =
      {{(ACC_W-STATE_WIDTH+1){1'b0}}, {(STATE_WIDTH-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] W_MIN =
      {{(ACC_W-STATE_WIDTH+1){1'b1}}, {(STATE_WIDTH-1){1'b0}}};
   localparam logic signed [ACC_W-1:0] Y_MAX =
      {{(ACC_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] Y_MIN =
      {{(ACC_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

   logic signed [COEF_WIDTH-1:0]  b0_ff, b1_ff, b2_ff, a1_ff, a2_ff;
   logic signed [STATE_WIDTH-1:0] d1_ff, d2_ff, w_ff, w_in;
   logic signed [PROD_W-1:0]      prod_ff, prod_in;
   logic signed [ACC_W-1:0]       acc_ff, acc_in;
   logic signed [ACC_W-1:0]       prod_ext, x_ext, rounded, w_sat, y_sat;
   logic signed [SAMPLE_WIDTH-1:0] out_ff, out_in;
   logic signed [COEF_WIDTH-1:0]  mul_coef;
   logic signed [STATE_WIDTH-1:0] mul_state;

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_ff <= B0_RESET;
         b1_ff <= '0;
         b2_ff <= '0;
         a1_ff <= '0;
         a2_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_B0: b0_ff <= csr_write_data;
            REG_B1: b1_ff <= csr_write_data;
            REG_B2: b2_ff <= csr_write_data;
            REG_A1: a1_ff <= csr_write_data;
            REG_A2: a2_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (cmd.mul_sel)
         MUL_A1_D1: begin
            mul_coef = a1_ff;
            mul_state = d1_ff;
         end
         MUL_A2_D2: begin
            mul_coef = a2_ff;
            mul_state = d2_ff;
         end
         MUL_B0_W: begin
            mul_coef = b0_ff;
            mul_state = w_ff;
         end
         MUL_B1_D1: begin
            mul_coef = b1_ff;
            mul_state = d1_ff;
         end
         MUL_B2_D2: begin
            mul_coef = b2_ff;
            mul_state = d2_ff;
         end
         default: begin
            mul_coef = '0;
            mul_state = '0;
         end
      endcase
   end

   assign prod_in = mul_coef * mul_state;
   assign prod_ext = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign x_ext = {{(ACC_W-SAMPLE_WIDTH){sample_in[SAMPLE_WIDTH-1]}}, sample_in}
                  <<< COEF_FRAC_BITS;

   always_comb begin
      case (cmd.acc_op)
         ACC_LOAD_X: acc_in = x_ext;
         ACC_CLEAR:  acc_in = '0;
         ACC_ADD:    acc_in = acc_ff + prod_ext;
         ACC_SUB:    acc_in = acc_ff - prod_ext;
         default:    acc_in = acc_ff;
      endcase
   end

   assign rounded = (acc_ff + HALF) >>> COEF_FRAC_BITS;

   always_comb begin
      if (rounded > W_MAX) begin
         w_sat = W_MAX;
      end else if (rounded < W_MIN) begin
         w_sat = W_MIN;
      end else begin
         w_sat = rounded;
      end
      if (rounded > Y_MAX) begin
         y_sat = Y_MAX;
      end else if (rounded < Y_MIN) begin
         y_sat = Y_MIN;
      end else begin
         y_sat = rounded;
      end
   end

   assign w_in = w_sat[STATE_WIDTH-1:0];
   assign out_in = y_sat[SAMPLE_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (cmd.prod_en) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
      if (cmd.w_load) begin
         w_ff <= w_in;
      end
      if (cmd.out_load) begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_ff <= '0;
         d2_ff <= '0;
      end else if (cmd.out_load) begin
         d2_ff <= d1_ff;
         d1_ff <= w_ff;
      end
   end

   assign sample_out = out_ff;

endmodule

@@ src/bqd_controller.sv @@
module bqd_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bqd_pkg::cmd_type cmd
);
   import bqd_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_MUL1  = 4'd1;
   localparam logic [3:0] ST_MUL2  = 4'd2;
   localparam logic [3:0] ST_ACC2  = 4'd3;
   localparam logic [3:0] ST_WCALC = 4'd4;
   localparam logic [3:0] ST_MUL3  = 4'd5;
   localparam logic [3:0] ST_MUL4  = 4'd6;
   localparam logic [3:0] ST_MUL5  = 4'd7;
   localparam logic [3:0] ST_ACC5  = 4'd8;
   localparam logic [3:0] ST_OUT   = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       full_ff, full_in;
   logic       out_free;

   assign out_free = !full_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = full_ff;

   always_comb begin
      state_in = state_ff;
      cmd.mul_sel = MUL_A1_D1;
      cmd.prod_en = 1'b0;
      cmd.acc_op = ACC_HOLD;
      cmd.w_load = 1'b0;
      cmd.out_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.acc_op = ACC_LOAD_X;
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            cmd.mul_sel = MUL_A1_D1;
            cmd.prod_en = 1'b1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul_sel = MUL_A2_D2;
            cmd.prod_en = 1'b1;
            cmd.acc_op = ACC_SUB;
            state_in = ST_ACC2;
         end
         ST_ACC2: begin
            cmd.acc_op = ACC_SUB;
            state_in = ST_WCALC;
         end
         ST_WCALC: begin
            cmd.w_load = 1'b1;
            cmd.acc_op = ACC_CLEAR;
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            cmd.mul_sel = MUL_B0_W;
            cmd.prod_en = 1'b1;
            state_in = ST_MUL4;
         end
         ST_MUL4: begin
            cmd.mul_sel = MUL_B1_D1;
            cmd.prod_en = 1'b1;
            cmd.acc_op = ACC_ADD;
            state_in = ST_MUL5;
         end
         ST_MUL5: begin
            cmd.mul_sel = MUL_B2_D2;
            cmd.prod_en = 1'b1;
            cmd.acc_op = ACC_ADD;
            state_in = ST_ACC5;
         end
         ST_ACC5: begin
            cmd.acc_op = ACC_ADD;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      full_in = full_ff;
      if (cmd.out_load) begin
         full_in = 1'b1;
      end else if (rsp_ready) begin
         full_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         full_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         full_ff <= full_in;
      end
   end

endmodule

@@ src/biquad_direct_form_two.sv @@
// Each accepted sample steps through states MUL1 to OUT; a new request is taken only when idle.
// The single shared multiplier forms five products in sequence, with accumulate, round and
// saturate steps between them.
// The controller waits in its output state only while the previous response is still unread.
// A new request is taken while a finished response still waits in the output register.
// Reset (synchronous, active high) clears both delays, sets b0 to 1.0 and other coefficients to 0.
module biquad_direct_form_two #(
   parameter int SAMPLE_WIDTH = 24,
   parameter int COEF_FRAC_BITS = 20,
   parameter int STATE_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   bqd_req_if.sink                             req_if,
   bqd_rsp_if.source                           rsp_if,
   input  logic                                csr_write_enable,
   input  logic [bqd_pkg::REG_INDEX_WIDTH-1:0] csr_index,
   input  logic [bqd_pkg::COEF_WIDTH-1:0]      csr_write_data
);
   import bqd_pkg::*;

   cmd_type cmd;

   bqd_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd)
   );

   bqd_datapath #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS),
      .STATE_WIDTH    (STATE_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .sample_in        (req_if.sample_in),
      .cmd              (cmd),
      .sample_out       (rsp_if.sample_out)
   );

endmodule
